### sv/compass_hard_iron_cal_heading_macros.svh
// Assertion macros used by the compass heading sequencer (chic_ctrl).
`ifndef COMPASS_HARD_IRON_CAL_HEADING_MACROS_SVH
`define COMPASS_HARD_IRON_CAL_HEADING_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define CHIC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define CHIC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/chic_pkg.sv
// Shared constants, types and the CORDIC angle table for the compass heading block.
package chic_pkg;

    localparam int CORDIC_STEPS = 20;
    // Iterations actually run; the angle table has 32 entries.
    localparam int NITER  = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
    localparam int ITER_W = $clog2(NITER);
    // Vector width: 17-bit operand scaled by 2^16, CORDIC gain and sqrt(2) headroom.
    localparam int CORDIC_W = 38;

    localparam logic [1:0] CMD_MEASURE = 2'd0;
    localparam logic [1:0] CMD_CAL     = 2'd1;
    localparam logic [1:0] CMD_FINISH  = 2'd2;

    localparam logic [1:0] YAW_YZ = 2'd0;
    localparam logic [1:0] YAW_XZ = 2'd1;

    localparam logic [2:0] REG_DECL  = 3'd0;
    localparam logic [2:0] REG_YAW   = 3'd1;
    localparam logic [2:0] REG_XSPAN = 3'd2;
    localparam logic [2:0] REG_YSPAN = 3'd3;
    localparam logic [2:0] REG_ZSPAN = 3'd4;

    typedef struct packed {
        logic signed [8:0] declination;
        logic [1:0]        yaw_axis;
        logic [15:0]       x_span_min;
        logic [15:0]       y_span_min;
        logic [15:0]       z_span_min;
    } t_cfg;

    typedef struct packed {
        logic              capture;
        logic              load;
        logic              step;
        logic              deg;
        logic              load_out;
        logic [ITER_W-1:0] iter;
    } t_dp_cmd;

    typedef struct packed {
        logic measure;
        logic special;
    } t_dp_sts;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_angle(input logic [4:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:  a = 32'd536870912;
            5'd1:  a = 32'd316933406;
            5'd2:  a = 32'd167458907;
            5'd3:  a = 32'd85004756;
            5'd4:  a = 32'd42667331;
            5'd5:  a = 32'd21354465;
            5'd6:  a = 32'd10679838;
            5'd7:  a = 32'd5340245;
            5'd8:  a = 32'd2670163;
            5'd9:  a = 32'd1335087;
            5'd10: a = 32'd667544;
            5'd11: a = 32'd333772;
            5'd12: a = 32'd166886;
            5'd13: a = 32'd83443;
            5'd14: a = 32'd41722;
            5'd15: a = 32'd20861;
            5'd16: a = 32'd10430;
            5'd17: a = 32'd5215;
            5'd18: a = 32'd2608;
            5'd19: a = 32'd1304;
            5'd20: a = 32'd652;
            5'd21: a = 32'd326;
            5'd22: a = 32'd163;
            5'd23: a = 32'd81;
            5'd24: a = 32'd41;
            5'd25: a = 32'd20;
            5'd26: a = 32'd10;
            5'd27: a = 32'd5;
            5'd28: a = 32'd3;
            5'd29: a = 32'd1;
            5'd30: a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

### sv/chic_ctrl.sv
// Sequencer: input/output handshakes and CORDIC iteration count.
module chic_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  chic_pkg::t_dp_sts i_sts,
    output chic_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ITER,
        S_DEG,
        S_OUT
    } t_state;

    t_state                      r_state, n_state;
    logic [chic_pkg::ITER_W-1:0] r_cnt, n_cnt;
    logic                        r_out_valid, n_out_valid;
    logic                        last_iter;
    logic                        out_free;

    assign last_iter = (r_cnt == chic_pkg::ITER_W'(chic_pkg::NITER - 1));
    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.iter  = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_cnt      = '0;
                n_state    = i_sts.measure ? S_ITER : S_OUT;
            end
            S_ITER: begin
                if (i_sts.special) begin
                    n_state = S_DEG;
                end else begin
                    o_cmd.step = 1'b1;
                    if (last_iter) begin
                        n_state = S_DEG;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_DEG: begin
                o_cmd.deg = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

`include "compass_hard_iron_cal_heading_macros.svh"

    `CHIC_ASSERT_NOW(a_no_overwrite, o_cmd.load_out, !r_out_valid || i_out_ready, "result overwritten before transfer")
    `CHIC_ASSERT_NOW(a_no_step_special, o_cmd.step, !i_sts.special, "CORDIC step on exact-axis item")
    `CHIC_ASSERT_NOW(a_cnt_range, r_state == S_ITER, r_cnt <= chic_pkg::ITER_W'(chic_pkg::NITER - 1), "iteration count out of range")
    `CHIC_ASSERT_NEXT(a_accept_load, i_in_valid && o_in_ready, r_state == S_LOAD, "accepted item not loaded")

endmodule

### sv/chic_dp.sv
// Datapath: calibration state, correction, CORDIC vectoring and result register.
module chic_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  chic_pkg::t_cfg      i_cfg,
    input  chic_pkg::t_dp_cmd   i_cmd,
    output chic_pkg::t_dp_sts   o_sts,
    input  logic [1:0]          i_command,
    input  logic [15:0]         i_raw_x,
    input  logic [15:0]         i_raw_y,
    input  logic [15:0]         i_raw_z,
    output logic signed [9:0]   o_heading,
    output logic signed [16:0]  o_corr_x,
    output logic signed [16:0]  o_corr_y,
    output logic signed [16:0]  o_corr_z,
    output logic signed [15:0]  o_offset_x,
    output logic signed [15:0]  o_offset_y,
    output logic signed [15:0]  o_offset_z,
    output logic                o_span_ok_x,
    output logic                o_span_ok_y,
    output logic                o_span_ok_z
);

    localparam int W = chic_pkg::CORDIC_W;

    logic signed [15:0] r_min [3];
    logic signed [15:0] r_max [3];
    logic signed [15:0] r_off [3];
    logic signed [16:0] r_corr [3];
    logic               r_ok [3];
    logic [1:0]         r_cmd;

    logic signed [W-1:0] r_x, r_y;
    logic [31:0]         r_z;
    logic                r_special;
    logic [8:0]          r_sdeg;
    logic [8:0]          r_deg;

    logic signed [15:0] raw_s [3];
    logic signed [16:0] corr_c [3];
    logic signed [15:0] half_c [3];
    logic               ok_c [3];
    logic [15:0]        span_min [3];

    logic signed [16:0]  num, den;
    logic signed [W-1:0] x_init, y_init;
    logic signed [W-1:0] dx, dy;
    logic [31:0]         atan_c;
    logic [40:0]         deg_prod;
    logic signed [10:0]  hsum, hwrap;

    assign span_min[0] = i_cfg.x_span_min;
    assign span_min[1] = i_cfg.y_span_min;
    assign span_min[2] = i_cfg.z_span_min;

    // raw - 32768 is the raw word with its top bit flipped
    assign raw_s[0] = $signed({~i_raw_x[15], i_raw_x[14:0]});
    assign raw_s[1] = $signed({~i_raw_y[15], i_raw_y[14:0]});
    assign raw_s[2] = $signed({~i_raw_z[15], i_raw_z[14:0]});

    always_comb begin
        logic signed [16:0] sum, sum_adj, diff;
        for (int k = 0; k < 3; k++) begin
            corr_c[k] = $signed({raw_s[k][15], raw_s[k]}) - $signed({r_off[k][15], r_off[k]});
            sum       = $signed({r_max[k][15], r_max[k]}) + $signed({r_min[k][15], r_min[k]});
            // round toward zero: negative sums get +1 before the shift
            sum_adj   = sum + $signed({16'd0, sum[16]});
            half_c[k] = 16'(sum_adj >>> 1);
            diff      = $signed({r_max[k][15], r_max[k]}) - $signed({r_min[k][15], r_min[k]});
            ok_c[k]   = $signed({diff[16], diff}) >= $signed({2'b00, span_min[k]});
        end
    end

    // calibration state and captured item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_min[k] <= 16'sh7FFF;
                r_max[k] <= 16'sh8000;
                r_off[k] <= '0;
            end
        end else if (i_cmd.capture) begin
            for (int k = 0; k < 3; k++) begin
                if (i_command == chic_pkg::CMD_CAL) begin
                    if (raw_s[k] > r_max[k]) r_max[k] <= raw_s[k];
                    if (raw_s[k] < r_min[k]) r_min[k] <= raw_s[k];
                end
                if (i_command == chic_pkg::CMD_FINISH) begin
                    r_off[k] <= half_c[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd <= i_command;
            for (int k = 0; k < 3; k++) begin
                r_corr[k] <= (i_command == chic_pkg::CMD_MEASURE) ? corr_c[k] : '0;
                r_ok[k]   <= (i_command == chic_pkg::CMD_FINISH) ? ok_c[k] : 1'b0;
            end
        end
    end

    // operand pair for atan2(num, den)
    always_comb begin
        case (i_cfg.yaw_axis)
            chic_pkg::YAW_YZ: begin
                num = r_corr[1];
                den = r_corr[2];
            end
            chic_pkg::YAW_XZ: begin
                num = r_corr[0];
                den = r_corr[2];
            end
            default: begin
                num = r_corr[0];
                den = r_corr[1];
            end
        endcase
    end

    assign x_init = $signed({{(W-33){den[16]}}, den, 16'd0});
    assign y_init = $signed({{(W-33){num[16]}}, num, 16'd0});

    assign dx     = r_y >>> i_cmd.iter;
    assign dy     = r_x >>> i_cmd.iter;
    assign atan_c = chic_pkg::atan_angle(5'(i_cmd.iter));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_special <= (num == '0) || (den == '0);
            if (num == '0) begin
                r_sdeg <= den[16] ? 9'd180 : 9'd0;
            end else begin
                r_sdeg <= num[16] ? 9'd270 : 9'd90;
            end
            // left half-plane: rotate by half a turn first
            if (den[16]) begin
                r_x <= -x_init;
                r_y <= -y_init;
                r_z <= 32'h8000_0000;
            end else begin
                r_x <= x_init;
                r_y <= y_init;
                r_z <= '0;
            end
        end else if (i_cmd.step) begin
            if (!r_y[W-1]) begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + atan_c;
            end else begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - atan_c;
            end
        end
    end

    assign deg_prod = {9'd0, r_z} * 41'd360;

    always_ff @(posedge i_clk) begin
        if (i_cmd.deg) begin
            r_deg <= r_special ? r_sdeg : deg_prod[40:32];
        end
    end

    assign hsum  = $signed({2'b00, r_deg}) + $signed({{2{i_cfg.declination[8]}},
                                                      i_cfg.declination});
    assign hwrap = (hsum > 11'sd360) ? (hsum - 11'sd360) : hsum;

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_heading   <= (r_cmd == chic_pkg::CMD_MEASURE) ? hwrap[9:0] : '0;
            o_corr_x    <= r_corr[0];
            o_corr_y    <= r_corr[1];
            o_corr_z    <= r_corr[2];
            o_offset_x  <= r_off[0];
            o_offset_y  <= r_off[1];
            o_offset_z  <= r_off[2];
            o_span_ok_x <= r_ok[0];
            o_span_ok_y <= r_ok[1];
            o_span_ok_z <= r_ok[2];
        end
    end

    assign o_sts.measure = (r_cmd == chic_pkg::CMD_MEASURE);
    assign o_sts.special = r_special;

endmodule

### sv/compass_hard_iron_cal_heading.sv
// Top level: magnetometer hard-iron calibration and compass heading.
//
// Input channel (i_in_valid/o_in_ready) transfers one sample with a command:
//   measure, calibration sample or finish calibration. Output channel
//   (o_out_valid/i_out_ready) transfers exactly one result per input.
// Calibration samples widen per-axis min/max; finish sets offsets to the
//   window center and reports per-axis span checks; measure removes bias
//   and offset and returns the heading in whole degrees plus declination.
// Sequence: a measure item runs operand load, 20 CORDIC iterations, degree
//   scaling and output load; when the operand pair lies on an axis the
//   iterations are skipped, and calibrate and finish go from operand load
//   straight to output load. One item is in work at a time; the next transfer
//   is taken the cycle after the result loads.
// The result sits in an output register: once it is loaded the next input
//   is accepted even while the receiver stalls; a further result then waits
//   in the datapath until the register is taken.
// Reset (synchronous, active low): min = 32767, max = -32768, offsets 0,
//   declination 0, yaw axis 2, span thresholds 0, no result pending.
// Registers on APB, 4-byte stride: declination, yaw_axis, x/y/z span mins.
module compass_hard_iron_cal_heading (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // APB configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_command,
    input  logic [15:0]        i_raw_x,
    input  logic [15:0]        i_raw_y,
    input  logic [15:0]        i_raw_z,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [9:0]  o_heading,
    output logic signed [16:0] o_corr_x,
    output logic signed [16:0] o_corr_y,
    output logic signed [16:0] o_corr_z,
    output logic signed [15:0] o_offset_x,
    output logic signed [15:0] o_offset_y,
    output logic signed [15:0] o_offset_z,
    output logic               o_span_ok_x,
    output logic               o_span_ok_y,
    output logic               o_span_ok_z
);

    chic_pkg::t_cfg    r_cfg;
    chic_pkg::t_dp_cmd dp_cmd;
    chic_pkg::t_dp_sts dp_sts;
    logic              cfg_wr;
    logic [2:0]        reg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    // configuration registers; the user must write them only while the block is idle (not enforced here)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.declination <= '0;
            r_cfg.yaw_axis    <= 2'd2;
            r_cfg.x_span_min  <= '0;
            r_cfg.y_span_min  <= '0;
            r_cfg.z_span_min  <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                chic_pkg::REG_DECL:  r_cfg.declination <= $signed(pwdata[8:0]);
                chic_pkg::REG_YAW:   r_cfg.yaw_axis    <= pwdata[1:0];
                chic_pkg::REG_XSPAN: r_cfg.x_span_min  <= pwdata[15:0];
                chic_pkg::REG_YSPAN: r_cfg.y_span_min  <= pwdata[15:0];
                chic_pkg::REG_ZSPAN: r_cfg.z_span_min  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            chic_pkg::REG_DECL:  prdata = 32'(r_cfg.declination);
            chic_pkg::REG_YAW:   prdata = {30'd0, r_cfg.yaw_axis};
            chic_pkg::REG_XSPAN: prdata = {16'd0, r_cfg.x_span_min};
            chic_pkg::REG_YSPAN: prdata = {16'd0, r_cfg.y_span_min};
            chic_pkg::REG_ZSPAN: prdata = {16'd0, r_cfg.z_span_min};
            default:             prdata = '0;
        endcase
    end

    chic_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    chic_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_command   (i_command),
        .i_raw_x     (i_raw_x),
        .i_raw_y     (i_raw_y),
        .i_raw_z     (i_raw_z),
        .o_heading   (o_heading),
        .o_corr_x    (o_corr_x),
        .o_corr_y    (o_corr_y),
        .o_corr_z    (o_corr_z),
        .o_offset_x  (o_offset_x),
        .o_offset_y  (o_offset_y),
        .o_offset_z  (o_offset_z),
        .o_span_ok_x (o_span_ok_x),
        .o_span_ok_y (o_span_ok_y),
        .o_span_ok_z (o_span_ok_z)
    );

endmodule
